>>> hdl/clfol_pkg.sv
`default_nettype none

package clfol_pkg;

   localparam int CORDIC_STAGES  = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int LOG_TERMS      = 20;

   // datapath widths
   localparam int CW        = 36;                  // cordic x / y
   localparam int ZW        = 26;                  // angle, 1/32768 degree
   localparam int EXP_SHIFT = 8 + GAIN_FRAC_BITS;
   localparam int QW        = 47 - EXP_SHIFT;      // exponent argument, Q24 log2
   localparam int NW        = QW - 24;             // integer part of exponent
   localparam int DB_SHIFT  = 48 - GAIN_FRAC_BITS;
   localparam int GDW       = 59 - DB_SHIFT;       // rounded gain magnitude
   localparam int FW        = GDW + 2;             // gain before clipping

   localparam logic [29:0] DB_TO_LOG2 = 30'd713378626;
   localparam logic [29:0] INV_GAIN   = 30'd652032875;
   localparam logic [26:0] LOG2_TO_DB = 27'd101008905;

   localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1073741824);
   localparam logic signed [ZW-1:0] DEG90   = ZW'(32'sd2949120);
   localparam logic signed [ZW-1:0] DEG180  = ZW'(32'sd5898240);
   localparam logic signed [ZW:0]   PH_HALF = (ZW+1)'(32'sd23040);
   localparam logic signed [ZW:0]   PH_FULL = (ZW+1)'(32'sd46080);
   localparam logic signed [15:0]   GAIN_MAX = 16'sh7fff;
   localparam logic signed [15:0]   GAIN_MIN = 16'sh8000;

   typedef struct packed {
      logic [31:0]        frequency_code;
      logic               last_point;
      logic               big;
      logic signed [15:0] gain;
      logic signed [15:0] phase_w;
   } common_type;

   typedef struct packed {
      common_type    c;
      logic [24:0]   g;
      logic [31:0]   v;
      logic [NW-1:0] n;
   } exp_type;

   typedef struct packed {
      common_type           c;
      logic                 zero;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   typedef struct packed {
      common_type           c;
      logic                 nonpos;
      logic signed [ZW-1:0] argw;
      logic [4:0]           p;
      logic [32:0]          f;
      logic [24:0]          acc;
   } log_type;

   typedef struct packed {
      common_type           c;
      logic                 nonpos;
      logic signed [31:0]   l2;
      logic                 l2_neg;
      logic [30:0]          l2_mag;
      logic [57:0]          prod;
      logic [GDW-1:0]       gd_mag;
      logic signed [FW-1:0] gfin;
      logic                 ph_neg;
      logic [ZW:0]          ph_mag;
      logic signed [ZW:0]   ph;
   } tail_type;

   typedef struct packed {
      logic [31:0]        frequency_out;
      logic signed [15:0] closed_gain_db;
      logic signed [15:0] closed_phase;
      logic               saturated;
      logic               last_out;
   } result_type;

   // log2(1 + 2^-i) in Q24
   function automatic logic [24:0] log_tab(input logic [4:0] idx);
      case (idx)
         5'd1:    return 25'd9814042;
         5'd2:    return 25'd5401057;
         5'd3:    return 25'd2850868;
         5'd4:    return 25'd1467383;
         5'd5:    return 25'd744810;
         5'd6:    return 25'd375270;
         5'd7:    return 25'd188362;
         5'd8:    return 25'd94364;
         5'd9:    return 25'd47228;
         5'd10:   return 25'd23626;
         5'd11:   return 25'd11816;
         5'd12:   return 25'd5909;
         5'd13:   return 25'd2954;
         5'd14:   return 25'd1477;
         5'd15:   return 25'd739;
         5'd16:   return 25'd369;
         5'd17:   return 25'd185;
         5'd18:   return 25'd92;
         5'd19:   return 25'd46;
         5'd20:   return 25'd23;
         default: return 25'd0;
      endcase
   endfunction

   // atan(2^-i) in 1/32768 degree
   function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
      case (idx)
         5'd0:    return ZW'(32'sd1474560);
         5'd1:    return ZW'(32'sd870484);
         5'd2:    return ZW'(32'sd459940);
         5'd3:    return ZW'(32'sd233473);
         5'd4:    return ZW'(32'sd117189);
         5'd5:    return ZW'(32'sd58652);
         5'd6:    return ZW'(32'sd29333);
         5'd7:    return ZW'(32'sd14667);
         5'd8:    return ZW'(32'sd7334);
         5'd9:    return ZW'(32'sd3667);
         5'd10:   return ZW'(32'sd1833);
         5'd11:   return ZW'(32'sd917);
         5'd12:   return ZW'(32'sd458);
         5'd13:   return ZW'(32'sd229);
         5'd14:   return ZW'(32'sd115);
         5'd15:   return ZW'(32'sd57);
         5'd16:   return ZW'(32'sd29);
         5'd17:   return ZW'(32'sd14);
         5'd18:   return ZW'(32'sd7);
         5'd19:   return ZW'(32'sd4);
         5'd20:   return ZW'(32'sd2);
         5'd21:   return ZW'(32'sd1);
         default: return ZW'(32'sd0);
      endcase
   endfunction

endpackage

`default_nettype wire

>>> hdl/clfol_req_if.sv
`default_nettype none

interface clfol_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        frequency_code;
   logic signed [15:0] loop_gain_db;
   logic signed [15:0] loop_phase;
   logic               last_point;

   modport source (output valid, frequency_code, loop_gain_db, loop_phase, last_point,
                   input ready);
   modport sink (input valid, frequency_code, loop_gain_db, loop_phase, last_point,
                 output ready);
endinterface

`default_nettype wire

>>> hdl/clfol_rsp_if.sv
`default_nettype none

interface clfol_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        frequency_out;
   logic signed [15:0] closed_gain_db;
   logic signed [15:0] closed_phase;
   logic               saturated;
   logic               last_out;

   modport source (output valid, frequency_out, closed_gain_db, closed_phase, saturated,
                   last_out, input ready);
   modport sink (input valid, frequency_out, closed_gain_db, closed_phase, saturated,
                 last_out, output ready);
endinterface

`default_nettype wire

>>> hdl/closed_loop_from_open_loop_unit.sv
// Closed-loop point T = L/(1+L) from one open-loop point L.
//
// req_bus carries one open-loop point per beat: frequency code, gain in
// 1/256 dB, phase in 1/128 degree and a last-point mark. rsp_bus returns one
// closed-loop point per beat: gain in 1/256 dB (clipped, with the saturated
// flag), phase wrapped to the atan2 range, and the copied code and mark.
// Both channels use valid/ready; a beat moves when both are high.
//
// Throughput is one point per cycle while the skid register is empty; every
// step is its own pipeline stage (exponent terms, rotation and vectoring
// micro-rotations, logarithm terms).
//
// When the receiver stalls, the result in the output register holds and one
// more result fits in a skid register; while that skid register is full the
// whole pipeline holds and req_bus.ready is low. Synchronous reset empties the
// pipeline and both output registers; ready is high the cycle after reset.
`default_nettype none

module closed_loop_from_open_loop_unit (
   input wire logic    clock,
   input wire logic    reset,
   clfol_req_if.sink   req_bus,
   clfol_rsp_if.source rsp_bus
);

   localparam int CS = clfol_pkg::CORDIC_STAGES;
   localparam int LT = clfol_pkg::LOG_TERMS;
   localparam int CW = clfol_pkg::CW;
   localparam int ZW = clfol_pkg::ZW;
   localparam int FW = clfol_pkg::FW;

   logic adv;
   logic accept;

   // stage a: phase wrap and gain magnitude
   clfol_pkg::common_type a_in, a_ff;
   logic [15:0]           ag_in, ag_ff;
   logic                  a_valid_ff;
   logic signed [16:0]    pw17;
   logic signed [16:0]    g17;

   // stage b: gain to log2
   clfol_pkg::common_type b_ff;
   logic [45:0]           b_prod_in, b_prod_ff;
   logic                  b_valid_ff;

   // stage c: split exponent
   clfol_pkg::exp_type    c_in, c_ff;
   logic                  c_valid_ff;
   logic [46:0]           qsum;
   logic [clfol_pkg::QW-1:0] q;

   clfol_pkg::exp_type    exp_data [0:LT];
   logic                  exp_valid [0:LT];

   // stages d, e, f: scale and quadrant fold
   clfol_pkg::cordic_type d_in, d_ff, e_in, e_ff, f_in, f_ff, g_in, g_ff;
   logic                  d_valid_ff, e_valid_ff, f_valid_ff, g_valid_ff;
   logic [31:0]           vsh;
   logic [60:0]           e_prod;

   clfol_pkg::cordic_type rot_data [0:CS];
   logic                  rot_valid [0:CS];
   clfol_pkg::cordic_type vec_data [0:CS];
   logic                  vec_valid [0:CS];

   logic signed [CW-1:0]  wr;

   // stages h, i, j: magnitude and normalize
   clfol_pkg::log_type    h_in, h_ff, i_in, i_ff, j_in, j_ff;
   logic                  h_valid_ff, i_valid_ff, j_valid_ff;
   logic [61:0]           h_prod;
   logic [31:0]           m;

   clfol_pkg::log_type    log_data [0:LT];
   logic                  log_valid [0:LT];

   // tail stages k..o
   clfol_pkg::tail_type   k_in, k_ff, l_in, l_ff, m_in, m_ff, n_in, n_ff, o_in, o_ff;
   logic                  k_valid_ff, l_valid_ff, m_valid_ff, n_valid_ff, o_valid_ff;
   logic signed [ZW:0]    pw256;
   logic signed [ZW:0]    argw_e;
   logic [58:0]           gsum;
   logic signed [FW-1:0]  gext;
   logic signed [FW-1:0]  mag_e;
   logic signed [ZW:0]    ph_mod;

   // stage p: clip, pipeline head
   clfol_pkg::result_type p_in, p_ff;
   logic                  p_valid_ff;

   // output register and skid
   clfol_pkg::result_type out_ff, skid_ff;
   logic                  out_valid_ff, skid_valid_ff;
   logic                  pop, push;

   assign adv           = !skid_valid_ff;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;

   // ---------------- stage a
   always_comb begin
      pw17 = 17'(req_bus.loop_phase);
      if (pw17 > 17'sd23040) begin
         pw17 = pw17 - 17'sd46080;
      end else if (pw17 <= -17'sd23040) begin
         pw17 = pw17 + 17'sd46080;
      end
      g17                 = 17'(req_bus.loop_gain_db);
      a_in.frequency_code = req_bus.frequency_code;
      a_in.last_point     = req_bus.last_point;
      a_in.big            = (req_bus.loop_gain_db > 16'sd0);
      a_in.gain           = req_bus.loop_gain_db;
      a_in.phase_w        = pw17[15:0];
      ag_in               = a_in.big ? g17[15:0] : 16'(-g17);
   end

   // ---------------- stage b
   assign b_prod_in = 46'(ag_ff) * 46'(clfol_pkg::DB_TO_LOG2);

   // ---------------- stage c
   always_comb begin
      qsum   = {1'b0, b_prod_ff} + (47'd1 << (clfol_pkg::EXP_SHIFT - 1));
      q      = qsum[46:clfol_pkg::EXP_SHIFT];
      c_in.c = b_ff;
      c_in.n = q[clfol_pkg::QW-1:24];
      c_in.g = 25'h1000000 - {1'b0, q[23:0]};
      c_in.v = 32'h40000000;
   end

   assign exp_data[0]  = c_ff;
   assign exp_valid[0] = c_valid_ff;

   genvar k;
   generate
      for (k = 1; k <= LT; k++) begin : g_exp
         clfol_exp_cell u_exp (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .stage_idx (5'(k)),
            .up_valid  (exp_valid[k-1]),
            .up_data   (exp_data[k-1]),
            .dn_valid  (exp_valid[k]),
            .dn_data   (exp_data[k])
         );
      end
   endgenerate

   // ---------------- stage d: r = v >> (n + 1), start angle
   always_comb begin
      vsh       = exp_data[LT].v >> exp_data[LT].n;
      d_in.c    = exp_data[LT].c;
      d_in.zero = 1'b0;
      d_in.x    = CW'(vsh[31:1]);
      d_in.y    = '0;
      d_in.z    = ZW'(signed'({exp_data[LT].c.phase_w, 8'h00}));
      if (exp_data[LT].c.big) begin
         d_in.z = -d_in.z;
      end
   end

   // ---------------- stage e: pre-scale by the inverse cordic gain
   always_comb begin
      e_prod = 61'(d_ff.x[30:0]) * 61'(clfol_pkg::INV_GAIN);
      e_in   = d_ff;
      e_in.x = CW'(e_prod[60:30]);
   end

   // ---------------- stage f: fold into +-90 degrees
   always_comb begin
      f_in = e_ff;
      if (e_ff.z > clfol_pkg::DEG90) begin
         f_in.z = e_ff.z - clfol_pkg::DEG180;
         f_in.x = -e_ff.x;
      end else if (e_ff.z < -clfol_pkg::DEG90) begin
         f_in.z = e_ff.z + clfol_pkg::DEG180;
         f_in.x = -e_ff.x;
      end
   end

   assign rot_data[0]  = f_ff;
   assign rot_valid[0] = f_valid_ff;

   generate
      for (k = 0; k < CS; k++) begin : g_rot
         clfol_cordic_cell u_rot (
            .clock       (clock),
            .reset       (reset),
            .adv         (adv),
            .stage_idx   (5'(k)),
            .vector_mode (1'b0),
            .up_valid    (rot_valid[k]),
            .up_data     (rot_data[k]),
            .dn_valid    (rot_valid[k+1]),
            .dn_data     (rot_data[k+1])
         );
      end
   endgenerate

   // ---------------- stage g: w = 1 + L, fold to right half plane
   always_comb begin
      wr        = rot_data[CS].x + clfol_pkg::ONE_Q30;
      g_in      = rot_data[CS];
      g_in.x    = wr;
      g_in.zero = (wr == '0) && (rot_data[CS].y == '0);
      g_in.z    = '0;
      if (wr[CW-1]) begin
         g_in.z = rot_data[CS].y[CW-1] ? -clfol_pkg::DEG180 : clfol_pkg::DEG180;
         g_in.x = -wr;
         g_in.y = -rot_data[CS].y;
      end
   end

   assign vec_data[0]  = g_ff;
   assign vec_valid[0] = g_valid_ff;

   generate
      for (k = 0; k < CS; k++) begin : g_vec
         clfol_cordic_cell u_vec (
            .clock       (clock),
            .reset       (reset),
            .adv         (adv),
            .stage_idx   (5'(k)),
            .vector_mode (1'b1),
            .up_valid    (vec_valid[k]),
            .up_data     (vec_data[k]),
            .dn_valid    (vec_valid[k+1]),
            .dn_data     (vec_data[k+1])
         );
      end
   endgenerate

   // ---------------- stage h: magnitude
   always_comb begin
      h_prod      = 62'(vec_data[CS].x[31:0]) * 62'(clfol_pkg::INV_GAIN);
      m           = h_prod[61:30];
      h_in.c      = vec_data[CS].c;
      h_in.nonpos = vec_data[CS].zero || vec_data[CS].x[CW-1] || (m == 32'd0);
      h_in.argw   = vec_data[CS].zero ? '0 : vec_data[CS].z;
      h_in.p      = '0;
      h_in.f      = {1'b0, m};
      h_in.acc    = '0;
   end

   // ---------------- stage i: leading one
   always_comb begin
      i_in = h_ff;
      for (int b = 0; b < 32; b++) begin
         if (h_ff.f[b]) begin
            i_in.p = 5'(b);
         end
      end
   end

   // ---------------- stage j: normalize to [1, 2) in Q30
   always_comb begin
      j_in = i_ff;
      if (i_ff.p == 5'd31) begin
         j_in.f = i_ff.f >> 1;
      end else begin
         j_in.f = i_ff.f << (5'd30 - i_ff.p);
      end
   end

   assign log_data[0]  = j_ff;
   assign log_valid[0] = j_valid_ff;

   generate
      for (k = 1; k <= LT; k++) begin : g_log
         clfol_log_cell u_log (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .stage_idx (5'(k)),
            .up_valid  (log_valid[k-1]),
            .up_data   (log_data[k-1]),
            .dn_valid  (log_valid[k]),
            .dn_data   (log_data[k])
         );
      end
   endgenerate

   // ---------------- stage k: log2 result and raw phase
   always_comb begin
      pw256       = (ZW+1)'(signed'({log_data[LT].c.phase_w, 8'h00}));
      argw_e      = (ZW+1)'(log_data[LT].argw);
      k_in        = '0;
      k_in.c      = log_data[LT].c;
      k_in.nonpos = log_data[LT].nonpos;
      k_in.l2     = ((signed'({27'd0, log_data[LT].p}) - 32'sd29) <<< 24)
                    - signed'({7'd0, log_data[LT].acc});
      k_in.ph     = log_data[LT].c.big ? -argw_e : pw256 - argw_e;
   end

   // ---------------- stage l: magnitudes for rounding
   always_comb begin
      l_in        = k_ff;
      l_in.l2_neg = k_ff.l2[31];
      l_in.l2_mag = k_ff.l2[31] ? 31'(-k_ff.l2) : k_ff.l2[30:0];
      l_in.ph_neg = k_ff.ph[ZW];
      l_in.ph_mag = k_ff.ph[ZW] ? (ZW+1)'(-k_ff.ph) + (ZW+1)'(128)
                                : (ZW+1)'(k_ff.ph) + (ZW+1)'(128);
   end

   // ---------------- stage m: log2 to dB, phase rounded
   always_comb begin
      m_in      = l_ff;
      m_in.prod = 58'(l_ff.l2_mag) * 58'(clfol_pkg::LOG2_TO_DB);
      m_in.ph   = l_ff.ph_neg ? -signed'(l_ff.ph_mag >> 8) : signed'(l_ff.ph_mag >> 8);
   end

   // ---------------- stage n: gain rounded, phase reduced modulo a turn
   always_comb begin
      gsum        = {1'b0, m_ff.prod} + (59'd1 << (clfol_pkg::DB_SHIFT - 1));
      n_in        = m_ff;
      n_in.gd_mag = gsum[58:clfol_pkg::DB_SHIFT];
      if (m_ff.ph >= clfol_pkg::PH_FULL) begin
         n_in.ph = m_ff.ph - clfol_pkg::PH_FULL;
      end else if (m_ff.ph <= -clfol_pkg::PH_FULL) begin
         n_in.ph = m_ff.ph + clfol_pkg::PH_FULL;
      end
   end

   // ---------------- stage o: closed gain, phase into atan2 range
   always_comb begin
      gext  = FW'(n_ff.c.gain);
      mag_e = signed'(FW'(n_ff.gd_mag));
      o_in  = n_ff;
      if (n_ff.c.big) begin
         o_in.gfin = n_ff.l2_neg ? mag_e : -mag_e;
      end else begin
         o_in.gfin = n_ff.l2_neg ? gext + mag_e : gext - mag_e;
      end
      ph_mod = n_ff.ph;
      if (ph_mod > clfol_pkg::PH_HALF) begin
         o_in.ph = ph_mod - clfol_pkg::PH_FULL;
      end else if (ph_mod <= -clfol_pkg::PH_HALF) begin
         o_in.ph = ph_mod + clfol_pkg::PH_FULL;
      end
   end

   // ---------------- stage p: clip
   always_comb begin
      p_in.frequency_out = o_ff.c.frequency_code;
      p_in.last_out      = o_ff.c.last_point;
      p_in.closed_phase  = o_ff.ph[15:0];
      p_in.saturated     = 1'b1;
      if (o_ff.nonpos) begin
         p_in.closed_gain_db = clfol_pkg::GAIN_MAX;
      end else if (o_ff.gfin > FW'(clfol_pkg::GAIN_MAX)) begin
         p_in.closed_gain_db = clfol_pkg::GAIN_MAX;
      end else if (o_ff.gfin < FW'(clfol_pkg::GAIN_MIN)) begin
         p_in.closed_gain_db = clfol_pkg::GAIN_MIN;
      end else begin
         p_in.closed_gain_db = o_ff.gfin[15:0];
         p_in.saturated      = 1'b0;
      end
   end

   // ---------------- pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= exp_valid[LT];
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= rot_valid[CS];
         h_valid_ff <= vec_valid[CS];
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= log_valid[LT];
         l_valid_ff <= k_valid_ff;
         m_valid_ff <= l_valid_ff;
         n_valid_ff <= m_valid_ff;
         o_valid_ff <= n_valid_ff;
         p_valid_ff <= o_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff      <= a_in;
         ag_ff     <= ag_in;
         b_ff      <= a_ff;
         b_prod_ff <= b_prod_in;
         c_ff      <= c_in;
         d_ff      <= d_in;
         e_ff      <= e_in;
         f_ff      <= f_in;
         g_ff      <= g_in;
         h_ff      <= h_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         l_ff      <= l_in;
         m_ff      <= m_in;
         n_ff      <= n_in;
         o_ff      <= o_in;
         p_ff      <= p_in;
      end
   end

   // ---------------- output register and skid
   assign pop  = out_valid_ff && rsp_bus.ready;
   assign push = adv && p_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= p_ff;
         end else begin
            skid_ff <= p_ff;
         end
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.frequency_out  = out_ff.frequency_out;
   assign rsp_bus.closed_gain_db = out_ff.closed_gain_db;
   assign rsp_bus.closed_phase   = out_ff.closed_phase;
   assign rsp_bus.saturated      = out_ff.saturated;
   assign rsp_bus.last_out       = out_ff.last_out;

endmodule

`default_nettype wire

>>> hdl/clfol_exp_cell.sv
`default_nettype none

// one term of the bit-serial exponent
module clfol_exp_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic [4:0]         stage_idx,
   input  wire logic               up_valid,
   input  wire clfol_pkg::exp_type up_data,
   output logic                    dn_valid,
   output clfol_pkg::exp_type      dn_data
);

   logic               valid_ff;
   clfol_pkg::exp_type data_ff;
   clfol_pkg::exp_type data_in;
   logic [24:0]        tab;

   always_comb begin
      tab     = clfol_pkg::log_tab(stage_idx);
      data_in = up_data;
      if (up_data.g >= tab) begin
         data_in.g = up_data.g - tab;
         data_in.v = up_data.v + (up_data.v >> stage_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

>>> hdl/clfol_cordic_cell.sv
`default_nettype none

// one micro-rotation, rotation or vectoring mode
module clfol_cordic_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic [4:0]            stage_idx,
   input  wire logic                  vector_mode,
   input  wire logic                  up_valid,
   input  wire clfol_pkg::cordic_type up_data,
   output logic                       dn_valid,
   output clfol_pkg::cordic_type      dn_data
);

   logic                            valid_ff;
   clfol_pkg::cordic_type           data_ff;
   clfol_pkg::cordic_type           data_in;
   logic signed [clfol_pkg::CW-1:0] xs;
   logic signed [clfol_pkg::CW-1:0] ys;
   logic signed [clfol_pkg::ZW-1:0] ang;
   logic                            dir;

   always_comb begin
      xs      = up_data.x >>> stage_idx;
      ys      = up_data.y >>> stage_idx;
      ang     = clfol_pkg::atan_tab(stage_idx);
      // vectoring drives y toward zero, rotation drives z toward zero
      dir     = vector_mode ? !(up_data.y > 0) : !up_data.z[clfol_pkg::ZW-1];
      data_in = up_data;
      if (dir) begin
         data_in.x = up_data.x - ys;
         data_in.y = up_data.y + xs;
         data_in.z = up_data.z - ang;
      end else begin
         data_in.x = up_data.x + ys;
         data_in.y = up_data.y - xs;
         data_in.z = up_data.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

>>> hdl/clfol_log_cell.sv
`default_nettype none

// one term of the bit-serial logarithm
module clfol_log_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic [4:0]         stage_idx,
   input  wire logic               up_valid,
   input  wire clfol_pkg::log_type up_data,
   output logic                    dn_valid,
   output clfol_pkg::log_type      dn_data
);

   logic               valid_ff;
   clfol_pkg::log_type data_ff;
   clfol_pkg::log_type data_in;
   logic [32:0]        t;

   always_comb begin
      t       = up_data.f + (up_data.f >> stage_idx);
      data_in = up_data;
      if (t <= 33'h080000000) begin
         data_in.f   = t;
         data_in.acc = up_data.acc + clfol_pkg::log_tab(stage_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

>>> hdl/clfol_checker.sv
`default_nettype none

module clfol_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] closed_gain_db,
   input wire logic [15:0] closed_phase,
   input wire logic        saturated
);

   // a stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // phase always in the atan2 range
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(closed_phase) >= -16'sd23039) &&
                    ($signed(closed_phase) <= 16'sd23040))
      else $error("closed_phase out of range");

   // the flag is only set at a range end
   a_sat_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (closed_gain_db != 16'h7fff) && (closed_gain_db != 16'h8000)
      |-> !saturated)
      else $error("saturated set with gain inside range");

   // reset empties the output and opens the input
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not empty after reset");

endmodule

bind closed_loop_from_open_loop_unit clfol_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .closed_gain_db (rsp_bus.closed_gain_db),
   .closed_phase   (rsp_bus.closed_phase),
   .saturated      (rsp_bus.saturated)
);

`default_nettype wire

>>> bench/tb_closed_loop_from_open_loop_unit.sv
`default_nettype none

module tb_closed_loop_from_open_loop_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ATAN_T [0:23] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};
   localparam longint LOG_T [0:20] = '{
      0, 9814042, 5401057, 2850868, 1467383, 744810, 375270, 188362, 94364,
      47228, 23626, 11816, 5909, 2954, 1477, 739, 369, 185, 92, 46, 23};
   localparam longint Q30 = 64'sd1 << 30;
   localparam longint Q24 = 64'sd1 << 24;
   localparam longint D90 = 2949120;
   localparam longint D180 = 5898240;
   localparam longint INV_K = 652032875;
   localparam int N_RANDOM = 550;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int accepted = 0;
   bit stimulus_done = 1'b0;

   clfol_req_if req_bus ();
   clfol_rsp_if rsp_bus ();

   closed_loop_from_open_loop_unit dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always #1 clock = ~clock;

   function automatic longint round_sh(longint v, int s);
      longint half;
      half = 64'sd1 << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
   endfunction

   function automatic longint wrap_ph(longint v);
      longint m;
      m = v % 46080;
      if (m > 23040) m -= 46080;
      if (m <= -23040) m += 46080;
      return m;
   endfunction

   // 10^(-ag/20) in q30 for ag >= 0
   function automatic longint gain_to_mag(longint ag);
      longint q, n, g, v;
      q = (ag * 713378626 + (64'sd1 << (clfol_pkg::EXP_SHIFT - 1))) >>> clfol_pkg::EXP_SHIFT;
      n = q >>> 24;
      g = Q24 - (q & (Q24 - 1));
      v = Q30;
      for (int i = 1; i <= 20; i++) begin
         if (g >= LOG_T[i]) begin
            g -= LOG_T[i];
            v += v >>> i;
         end
      end
      if (n + 1 > 62) return 0;
      return v >>> (n + 1);
   endfunction

   function automatic longint mag_log2(longint m);
      int p;
      longint f, acc, t;
      p = 0;
      acc = 0;
      while (p < 62 && (m >>> (p + 1)) != 0) p++;
      f = (p > 30) ? (m >>> (p - 30)) : (m << (30 - p));
      for (int i = 1; i <= 20; i++) begin
         t = f + (f >>> i);
         if (t <= 2 * Q30) begin
            f = t;
            acc += LOG_T[i];
         end
      end
      return longint'(p - 30) * Q24 + Q24 - acc;
   endfunction

   function automatic clfol_pkg::result_type closed_point(logic [31:0] freq,
                                                          logic signed [15:0] gain,
                                                          logic signed [15:0] phase,
                                                          logic last);
      clfol_pkg::result_type res;
      longint g, pw, ag, r, x, y, z, nx, wr, wi, argw, m, gd, ph;
      bit big, sat;
      g = gain;
      pw = wrap_ph(longint'(phase));
      big = g > 0;
      ag = big ? g : -g;
      r = gain_to_mag(ag);
      y = 0;
      argw = 0;
      m = 0;
      sat = 0;
      z = pw * 256;
      if (big) z = -z;
      x = (r * INV_K) >>> 30;
      if (z > D90) begin
         z -= D180;
         x = -x;
      end else if (z < -D90) begin
         z += D180;
         x = -x;
      end
      for (int i = 0; i < clfol_pkg::CORDIC_STAGES && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_T[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_T[i];
         end
         x = nx;
      end
      wr = Q30 + x;
      wi = y;
      if (wr != 0 || wi != 0) begin
         z = 0;
         if (wr < 0) begin
            z = (wi >= 0) ? D180 : -D180;
            wr = -wr;
            wi = -wi;
         end
         for (int i = 0; i < clfol_pkg::CORDIC_STAGES && i < 24; i++) begin
            if (wi > 0) begin
               nx = wr + (wi >>> i);
               wi = wi - (wr >>> i);
               z += ATAN_T[i];
            end else begin
               nx = wr - (wi >>> i);
               wi = wi + (wr >>> i);
               z -= ATAN_T[i];
            end
            wr = nx;
         end
         argw = z;
         m = (wr * INV_K) >>> 30;
      end
      if (m <= 0) begin
         gd = 32767;
         sat = 1;
      end else begin
         gd = round_sh(mag_log2(m) * 101008905, 48 - clfol_pkg::GAIN_FRAC_BITS);
         gd = big ? -gd : g - gd;
         if (gd > 32767) begin
            gd = 32767;
            sat = 1;
         end else if (gd < -32768) begin
            gd = -32768;
            sat = 1;
         end
      end
      ph = big ? -argw : pw * 256 - argw;
      ph = wrap_ph(round_sh(ph, 8));
      res.frequency_out = freq;
      res.closed_gain_db = 16'(gd);
      res.closed_phase = 16'(ph);
      res.saturated = sat;
      res.last_out = last;
      return res;
   endfunction

   class closed_point_board;
      clfol_pkg::result_type pending[$];
      int errors = 0;

      function void note_point(logic [31:0] freq, logic signed [15:0] gain,
                               logic signed [15:0] phase, logic last);
         pending.push_back(closed_point(freq, gain, phase, last));
      endfunction

      function void check_point(clfol_pkg::result_type got);
         clfol_pkg::result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("freq %h: expected gain %0d phase %0d sat %b last %b, got %h %0d %0d %b %b",
                        want.frequency_out, want.closed_gain_db, want.closed_phase,
                        want.saturated, want.last_out, got.frequency_out,
                        got.closed_gain_db, got.closed_phase, got.saturated, got.last_out);
         end
      endfunction
   endclass

   closed_point_board board = new();

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 70) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_point(logic [31:0] freq, logic signed [15:0] gain,
                             logic signed [15:0] phase, logic last, int gap);
      req_bus.valid <= 1'b1;
      req_bus.frequency_code <= freq;
      req_bus.loop_gain_db <= gain;
      req_bus.loop_phase <= phase;
      req_bus.last_point <= last;
      do @(posedge clock); while (!req_bus.ready);
      board.note_point(freq, gain, phase, last);
      accepted++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(bit calm);
      logic signed [15:0] gain, phase;
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) gain = 16'($urandom_range(0, 6000)) - 16'sd3000;
      else if (k < 70) gain = 16'($urandom_range(0, 600)) - 16'sd300;
      else gain = 16'($urandom);
      if (k >= 45 && k < 70) begin
         // near minus one: 1+L close to zero
         phase = 16'sd23040 - 16'($urandom_range(0, 400));
         if ($urandom_range(0, 1)) phase = -phase;
      end else begin
         phase = 16'($urandom_range(0, 46080)) - 16'sd23040;
      end
      send_point($urandom, gain, phase, $urandom_range(0, 7) == 0, calm ? 0 : pick_gap());
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.frequency_code = '0;
      req_bus.loop_gain_db = '0;
      req_bus.loop_phase = '0;
      req_bus.last_point = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_point(32'h0000_0000, clfol_pkg::GAIN_MIN, 16'sd0, 1'b0, 0);
      send_point(32'hffff_ffff, clfol_pkg::GAIN_MAX, 16'sd0, 1'b1, 0);
      send_point(32'h1234_5678, 16'sd0, 16'sd23040, 1'b0, 1);
      send_point(32'h8765_4321, 16'sd0, -16'sd23040, 1'b0, 0);
      send_point(32'h0000_0001, 16'sd0, 16'sd0, 1'b0, 0);
      send_point(32'h8000_0000, 16'sd1, 16'sd0, 1'b1, 2);
      send_point(32'h7fff_ffff, -16'sd1, 16'sd11520, 1'b0, 0);
      send_point(32'h5555_aaaa, clfol_pkg::GAIN_MIN, -16'sd23040, 1'b1, 0);
      send_point(32'haaaa_5555, clfol_pkg::GAIN_MAX, 16'sd23040, 1'b0, 0);
      send_point(32'h0f0f_0f0f, 16'sd100, 16'sd23000, 1'b0, 0);
      send_point(32'hf0f0_f0f0, -16'sd100, -16'sd23000, 1'b1, 0);
      send_point(32'h0000_ffff, 16'sd6000, -16'sd11520, 1'b0, 0);
      send_point(32'hffff_0000, -16'sd6000, 16'sd17280, 1'b0, 0);
      send_point(32'h0101_0101, -16'sd20000, 16'sd5760, 1'b1, 0);
      send_point(32'h1010_1010, 16'sd20000, 16'sd1, 1'b0, 0);
      send_point(32'h2222_2222, 16'sd3, -16'sd23039, 1'b0, 5);
      for (int i = 0; i < N_RANDOM; i++)
         send_random((i / 60) % 3 == 1);
      req_bus.valid <= 1'b0;
      stimulus_done = 1'b1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (board.errors == 0) $display("closed_loop_from_open_loop_unit: match");
      else $display("closed_loop_from_open_loop_unit: mismatch");
      $finish;
   end

   // result side: random stalls plus one long hold-off to back up the pipeline
   initial begin
      int hold;
      bit held_once;
      clfol_pkg::result_type got;
      hold = 0;
      held_once = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.frequency_out = rsp_bus.frequency_out;
            got.closed_gain_db = rsp_bus.closed_gain_db;
            got.closed_phase = rsp_bus.closed_phase;
            got.saturated = rsp_bus.saturated;
            got.last_out = rsp_bus.last_out;
            board.check_point(got);
         end
         if (!held_once && accepted >= 200) begin
            held_once = 1;
            hold = 400;
         end else if (hold == 0 && !stimulus_done) begin
            if ((accepted / 50) % 4 == 2) hold = 0;
            else if ($urandom_range(0, 9) < 3) hold = pick_gap() + 1;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ~reset;
         end
      end
   end

   initial begin
      #400000;
      $display("closed_loop_from_open_loop_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
